// ----- design/lpmr_pkg.sv -----
package lpmr_pkg;

  localparam int unsigned AddrBits = 32;
  localparam int unsigned LenBits = 6;
  localparam int unsigned IfaceBits = 3;
  localparam int unsigned TtlBits = 8;
  localparam int unsigned NumInterfaces = 8;
  localparam logic [LenBits-1:0] MaxLen = 6'd32;
  localparam logic [TtlBits-1:0] MinTtl = 8'd1;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_ROUTE = 1'b1
  } command_e;

  typedef enum logic [2:0] {
    ST_FORWARDED   = 3'd0,
    ST_STORED      = 3'd1,
    ST_NO_ROUTE    = 3'd2,
    ST_TTL_EXPIRED = 3'd3,
    ST_TABLE_FULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic                 command;
    logic [AddrBits-1:0]  net_addr;
    logic [LenBits-1:0]   mask_len;
    logic                 has_next_hop;
    logic [AddrBits-1:0]  gateway_addr;
    logic [IfaceBits-1:0] route_interface;
    logic [AddrBits-1:0]  dest_addr;
    logic [TtlBits-1:0]   ttl_in;
  } req_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [IfaceBits-1:0] send_interface;
    logic [AddrBits-1:0]  next_hop_out;
    logic [TtlBits-1:0]   ttl_out;
  } rsp_t;

  typedef struct packed {
    logic [AddrBits-1:0]  prefix;
    logic [LenBits-1:0]   len;
    logic                 has_hop;
    logic [AddrBits-1:0]  gateway;
    logic [IfaceBits-1:0] iface;
  } entry_t;

  typedef struct packed {
    logic load;
    logic read;
    logic done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [AddrBits-1:0] len_mask(input logic [LenBits-1:0] len);
    return ~({AddrBits{1'b1}} >> len);
  endfunction

  function automatic logic [LenBits-1:0] sat_len(input logic [LenBits-1:0] len);
    return (len > MaxLen) ? MaxLen : len;
  endfunction

endpackage

// ----- design/lpmr_req_if.sv -----
interface lpmr_req_if
  import lpmr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [AddrBits-1:0]  net_addr;
  logic [LenBits-1:0]   mask_len;
  logic                 has_next_hop;
  logic [AddrBits-1:0]  gateway_addr;
  logic [IfaceBits-1:0] route_interface;
  logic [AddrBits-1:0]  dest_addr;
  logic [TtlBits-1:0]   ttl_in;

  modport source (
    output valid, command, net_addr, mask_len, has_next_hop,
           gateway_addr, route_interface, dest_addr, ttl_in,
    input  ready
  );

  modport sink (
    input  valid, command, net_addr, mask_len, has_next_hop,
           gateway_addr, route_interface, dest_addr, ttl_in,
    output ready
  );
endinterface

// ----- design/lpmr_rsp_if.sv -----
interface lpmr_rsp_if
  import lpmr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic [IfaceBits-1:0] send_interface;
  logic [AddrBits-1:0]  next_hop_out;
  logic [TtlBits-1:0]   ttl_out;

  modport source (
    output valid, status, send_interface, next_hop_out, ttl_out,
    input  ready
  );

  modport sink (
    input  valid, status, send_interface, next_hop_out, ttl_out,
    output ready
  );
endinterface

// ----- design/lpmr_ctrl.sv -----
module lpmr_ctrl
  import lpmr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.empty ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.read = 1'b1;
        if (sts_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.done = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lpmr_dp.sv -----
module lpmr_dp
  import lpmr_pkg::*;
#(
  parameter int unsigned MAX_ROUTES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  req_t      req_i,
  input  ctrl_cmd_t cmd_i,
  output ctrl_sts_t sts_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  output rsp_t      rsp_o
);

  localparam int unsigned AW = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
  localparam int unsigned CW = $clog2(MAX_ROUTES + 1);

  entry_t               mem [MAX_ROUTES];
  entry_t               rd_q;
  req_t                 item_q;
  logic [AW-1:0]        addr_q;
  logic [AW-1:0]        rd_idx_q;
  logic                 rd_valid_q;
  logic [CW-1:0]        count_q;
  logic                 match_q;
  logic [AW-1:0]        match_idx_q;
  logic                 best_q;
  logic [LenBits-1:0]   best_len_q;
  logic                 best_hop_q;
  logic [AddrBits-1:0]  best_gw_q;
  logic [IfaceBits-1:0] best_iface_q;
  logic                 rsp_valid_q;
  rsp_t                 rsp_q, rsp_d;

  req_t                 load_item;
  logic                 is_add;
  logic                 add_hit;
  logic                 route_hit;
  logic                 table_full;
  logic                 wr_en;
  logic [AW-1:0]        wr_idx;
  entry_t               wr_data;
  logic                 out_free;

  assign is_add     = (item_q.command == CMD_ADD);
  assign table_full = (count_q == CW'(MAX_ROUTES));
  assign out_free   = !rsp_valid_q || rsp_ready_i;

  assign add_hit = rd_valid_q && is_add && (rd_q.len == item_q.mask_len)
                   && (rd_q.prefix == item_q.net_addr);
  assign route_hit = rd_valid_q && !is_add
                     && ((item_q.dest_addr & len_mask(rd_q.len)) == rd_q.prefix)
                     && (!best_q || (rd_q.len > best_len_q));

  assign wr_en  = cmd_i.done && is_add && (match_q || !table_full);
  assign wr_idx = match_q ? match_idx_q : count_q[AW-1:0];

  always_comb begin
    load_item          = req_i;
    load_item.mask_len = sat_len(req_i.mask_len);
    load_item.net_addr = req_i.net_addr & len_mask(sat_len(req_i.mask_len));
  end

  always_comb begin
    wr_data.prefix  = item_q.net_addr;
    wr_data.len     = item_q.mask_len;
    wr_data.has_hop = item_q.has_next_hop;
    wr_data.gateway = item_q.gateway_addr;
    wr_data.iface   = item_q.route_interface;
  end

  always_comb begin
    rsp_d = '0;
    if (is_add) begin
      rsp_d.status = (match_q || !table_full) ? ST_STORED : ST_TABLE_FULL;
    end else if (!best_q || (32'(best_iface_q) >= NumInterfaces)) begin
      rsp_d.status = ST_NO_ROUTE;
    end else if (item_q.ttl_in <= MinTtl) begin
      rsp_d.status = ST_TTL_EXPIRED;
    end else begin
      rsp_d.status         = ST_FORWARDED;
      rsp_d.send_interface = best_iface_q;
      rsp_d.next_hop_out   = best_hop_q ? best_gw_q : item_q.dest_addr;
      rsp_d.ttl_out        = item_q.ttl_in - MinTtl;
    end
  end

  always_comb begin
    sts_o.empty    = (count_q == '0);
    sts_o.last     = ((CW'(addr_q) + CW'(1)) == count_q);
    sts_o.out_free = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (cmd_i.read) begin
      rd_q     <= mem[addr_q];
      rd_idx_q <= addr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      addr_q      <= '0;
      rd_valid_q  <= 1'b0;
      match_q     <= 1'b0;
      best_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.read;
      if (cmd_i.load) begin
        addr_q  <= '0;
        match_q <= 1'b0;
        best_q  <= 1'b0;
      end else begin
        if (cmd_i.read) begin
          addr_q <= addr_q + AW'(1);
        end
        if (add_hit) begin
          match_q <= 1'b1;
        end
        if (route_hit) begin
          best_q <= 1'b1;
        end
      end
      if (cmd_i.done && is_add && !match_q && !table_full) begin
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= load_item;
    end
    if (add_hit) begin
      match_idx_q <= rd_idx_q;
    end
    if (route_hit) begin
      best_len_q   <= rd_q.len;
      best_hop_q   <= rd_q.has_hop;
      best_gw_q    <= rd_q.gateway;
      best_iface_q <= rd_q.iface;
    end
    if (cmd_i.done) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ROUTES))
    else $error("route count beyond table depth");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == ($past(count_q) + CW'(1))))
    else $error("route count moved by more than one");

  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |-> out_free)
    else $error("result loaded over an untaken result");

  a_read_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_valid_q |-> $past(cmd_i.read))
    else $error("read data flagged without a read");

endmodule

// ----- design/ipv4_longest_prefix_router_top.sv -----
// IPv4 longest-prefix-match router with a flat route table.
// req_i carries one transaction per item: command 0 adds a route (prefix,
// length, optional gateway, interface), command 1 routes one datagram
// (destination, TTL). rsp_o returns exactly one result transaction per item
// with a status code and, when forwarded, interface, next hop and TTL - 1.
// Both channels transfer when valid and ready are high at a rising clk_i.
// Every item scans the stored routes, one entry per cycle from a single-port
// table memory with registered read data; routes fill the table in order and
// are never removed. After acceptance the controller scans the stored routes,
// waits in a drain step for the last read data and then loads the result
// (straight to that final step when the table is empty); the next item can be
// accepted only after the result is loaded.
// req_i.ready is high only between items, one item is worked on at a time.
// A result waiting in the output register does not block the next item; the
// block holds in its final step only if the previous result is still untaken.
// rst_ni (asynchronous, active low) empties the route table at once.
module ipv4_longest_prefix_router_top
  import lpmr_pkg::*;
#(
  parameter int unsigned MAX_ROUTES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  lpmr_req_if.sink          req_i,
  lpmr_rsp_if.source        rsp_o
);

  req_t      req;
  rsp_t      rsp;
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_ready;

  always_comb begin
    req.command         = req_i.command;
    req.net_addr        = req_i.net_addr;
    req.mask_len        = req_i.mask_len;
    req.has_next_hop    = req_i.has_next_hop;
    req.gateway_addr    = req_i.gateway_addr;
    req.route_interface = req_i.route_interface;
    req.dest_addr       = req_i.dest_addr;
    req.ttl_in          = req_i.ttl_in;
  end

  assign req_i.ready          = in_ready;
  assign rsp_o.status         = rsp.status;
  assign rsp_o.send_interface = rsp.send_interface;
  assign rsp_o.next_hop_out   = rsp.next_hop_out;
  assign rsp_o.ttl_out        = rsp.ttl_out;

  lpmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lpmr_dp #(
    .MAX_ROUTES (MAX_ROUTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp)
  );

endmodule
